### src/nsd_pkg.sv
// shared types and constants for the netstring deframer
`default_nettype none

package nsd_pkg;

   // width of the length accumulator, saturates at all ones
   localparam int LENGTH_WIDTH = 13;
   // width of the max_length register
   localparam int MAX_LEN_WIDTH = 13;
   // common width for the length check at the colon
   localparam int CMP_WIDTH = (LENGTH_WIDTH > MAX_LEN_WIDTH) ? LENGTH_WIDTH : MAX_LEN_WIDTH;

   localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = MAX_LEN_WIDTH'(4096);

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      CLS_DIGIT,
      CLS_COLON,
      CLS_COMMA,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [1:0] {
      ST_DATA   = 2'd0,
      ST_CLOSED = 2'd1,
      ST_FORMAT = 2'd2,
      ST_LENGTH = 2'd3
   } status_type;

   // one classified byte as it travels from front to back
   typedef struct packed {
      logic [7:0]     data;
      char_class_type cls;
      logic [3:0]     digit;
   } item_type;

endpackage

`default_nettype wire

### src/nsd_front.sv
// front end: classifies each incoming byte and pushes it into the queue
`default_nettype none

module nsd_front
   import nsd_pkg::*;
(
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       q_full,
   output      logic       q_push,
   output      item_type   q_item
);

   logic is_digit;

   assign is_digit  = (req_byte_in >= CH_ZERO) && (req_byte_in <= CH_NINE);
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.data  = req_byte_in;
      q_item.digit = is_digit ? 4'(req_byte_in - CH_ZERO) : 4'd0;
      if (is_digit) begin
         q_item.cls = CLS_DIGIT;
      end else if (req_byte_in == CH_COLON) begin
         q_item.cls = CLS_COLON;
      end else if (req_byte_in == CH_COMMA) begin
         q_item.cls = CLS_COMMA;
      end else begin
         q_item.cls = CLS_OTHER;
      end
   end

endmodule

`default_nettype wire

### src/nsd_queue.sv
// short queue of classified bytes between front and back
`default_nettype none

module nsd_queue
   import nsd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output      logic     full,
   input  wire logic     pop,
   output      logic     head_valid,
   output      item_type head_item
);

   item_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   function automatic logic [QPTR_WIDTH-1:0] ptr_next(input logic [QPTR_WIDTH-1:0] p);
      ptr_next = (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### src/nsd_back.sv
// back end: netstring parser, max_length register and response register
`default_nettype none

module nsd_back
   import nsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire item_type                 head_item,
   output      logic                     pop,
   input  wire logic                     csr_wr_en,
   input  wire logic [MAX_LEN_WIDTH-1:0] csr_wr_data,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [7:0]               rsp_payload_byte,
   output      logic [1:0]               rsp_status
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_DIGITS,
      PH_PAYLOAD,
      PH_COMMA,
      PH_DEAD
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0]  frame_len_ff, frame_len_in;
   logic [LENGTH_WIDTH-1:0]  left_ff, left_in;
   logic [MAX_LEN_WIDTH-1:0] max_len_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     emit;

   logic [LENGTH_WIDTH+3:0]  acc_wide;
   logic [LENGTH_WIDTH-1:0]  acc_sat;
   logic [LENGTH_WIDTH-1:0]  left_dec;
   logic                     too_long;

   // response slot is free or is being emptied this cycle
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   assign acc_wide = {4'd0, frame_len_ff} * (LENGTH_WIDTH+4)'(10)
                   + (LENGTH_WIDTH+4)'(head_item.digit);
   assign acc_sat  = (acc_wide[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0) ? '1
                   : acc_wide[LENGTH_WIDTH-1:0];
   assign left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
   assign too_long = CMP_WIDTH'(frame_len_ff) > CMP_WIDTH'(max_len_ff);

   always_comb begin
      phase_in      = phase_ff;
      frame_len_in  = frame_len_ff;
      left_in       = left_ff;
      emit          = 1'b0;
      rsp_byte_in   = 8'd0;
      rsp_status_in = ST_DATA;
      if (pop) begin
         unique case (phase_ff)
            PH_FIRST: begin
               if (head_item.cls != CLS_DIGIT || head_item.digit == 4'd0) begin
                  phase_in      = PH_DEAD;
                  emit          = 1'b1;
                  rsp_status_in = ST_FORMAT;
               end else begin
                  frame_len_in = LENGTH_WIDTH'(head_item.digit);
                  phase_in     = PH_DIGITS;
               end
            end
            PH_DIGITS: begin
               if (head_item.cls == CLS_DIGIT) begin
                  frame_len_in = acc_sat;
               end else if (head_item.cls != CLS_COLON) begin
                  phase_in      = PH_DEAD;
                  emit          = 1'b1;
                  rsp_status_in = ST_FORMAT;
               end else if (too_long) begin
                  phase_in      = PH_DEAD;
                  emit          = 1'b1;
                  rsp_status_in = ST_LENGTH;
               end else begin
                  left_in  = frame_len_ff;
                  phase_in = (frame_len_ff == '0) ? PH_COMMA : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               left_in     = left_dec;
               phase_in    = (left_dec == '0) ? PH_COMMA : PH_PAYLOAD;
               emit        = 1'b1;
               rsp_byte_in = head_item.data;
            end
            PH_COMMA: begin
               emit = 1'b1;
               if (head_item.cls != CLS_COMMA) begin
                  phase_in      = PH_DEAD;
                  rsp_status_in = ST_FORMAT;
               end else begin
                  phase_in      = PH_FIRST;
                  frame_len_in  = '0;
                  left_in       = '0;
                  rsp_status_in = ST_CLOSED;
               end
            end
            default: begin
               phase_in = PH_DEAD;
            end
         endcase
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         frame_len_ff <= '0;
         left_ff      <= '0;
         max_len_ff   <= MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         frame_len_ff <= frame_len_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_status       = rsp_status_ff;

   // once dead, stays dead until reset
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DEAD |=> phase_ff == PH_DEAD)
      else $error("parser left dead phase");

   // every payload byte taken yields a data response
   assert property (@(posedge clock) disable iff (reset)
      (pop && phase_ff == PH_PAYLOAD) |=> (rsp_valid_ff && rsp_status_ff == ST_DATA))
      else $error("payload byte without data response");

   // a pending error response means the parser is dead
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FORMAT || rsp_status_ff == ST_LENGTH))
         |-> phase_ff == PH_DEAD)
      else $error("error response while parser alive");

   // remaining count never exceeds the frame length
   assert property (@(posedge clock) disable iff (reset)
      left_ff <= frame_len_ff)
      else $error("bytes left above frame length");

endmodule

`default_nettype wire

### src/netstring_deframer.sv
// netstring deframer top level
//
// takes a netstring byte stream (decimal length, colon, payload, comma), one
// request byte per cycle, and returns one response per payload byte (status 0
// with the byte), one per closed frame (status 1), or a single error (status 2
// for bad format: leading zero, empty length, non-digit, missing comma;
// status 3 for a length above max_length). length digits and the colon give no
// response. after an error all input is taken and dropped until reset.
// throughput is one byte per cycle: a front end classifies bytes into a
// two-entry queue and the back-end parser consumes one entry per cycle as long
// as its response register is empty or being taken; a byte passes through the
// queue and then the response register. max_length resets to 4096; the user
// writes it with csr_wr_en only while the block is idle; this is not enforced.
`default_nettype none

module netstring_deframer
   import nsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel: one raw stream byte
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [7:0]               req_byte_in,
   // response channel
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [7:0]               rsp_payload_byte,
   output      logic [1:0]               rsp_status,
   // max_length register
   input  wire logic                     csr_wr_en,
   input  wire logic [MAX_LEN_WIDTH-1:0] csr_wr_data
);

   logic     q_full;
   logic     q_push;
   item_type q_item;
   logic     q_pop;
   logic     q_valid;
   item_type q_head;

   // byte classification and request handshake
   nsd_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   // decouples request acceptance from response backpressure
   nsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_head)
   );

   // frame parser and response register
   nsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_valid),
      .head_item        (q_head),
      .pop              (q_pop),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire
